// File: src/ate_pkg.sv
// Shared types, codes and tables for the ANSI terminal command engine.
// Used by the controller, the datapath, the top level and the checker.
package ate_pkg;

  // Default configuration and sizes
  localparam int PARAM_SLOTS = 16;
  localparam int CELL_W      = 8;
  localparam int GLYPH_ROWS  = 8;
  localparam logic [11:0] WIDTH_RST  = 12'd1024;
  localparam logic [11:0] HEIGHT_RST = 12'd768;
  localparam logic [7:0]  BORDER_RST = 8'd8;
  localparam logic [3:0]  GAP_RST    = 4'd2;
  localparam logic [15:0] PARAM_MAX  = 16'hFFFF;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BORDER = 2'd2;
  localparam logic [1:0] REG_GAP    = 2'd3;

  // Render command codes
  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_GLYPH  = 3'd1;
  localparam logic [2:0] CMD_FILL   = 3'd2;
  localparam logic [2:0] CMD_SCROLL = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  // Parser modes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_ESC    = 2'd1;
  localparam logic [1:0] MODE_CSI    = 2'd2;

  // Character codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_UP    = 8'h41;  // A
  localparam logic [7:0] CH_DOWN  = 8'h42;  // B
  localparam logic [7:0] CH_FWD   = 8'h43;  // C
  localparam logic [7:0] CH_BACK  = 8'h44;  // D
  localparam logic [7:0] CH_HOME  = 8'h48;  // H
  localparam logic [7:0] CH_ED    = 8'h4A;  // J
  localparam logic [7:0] CH_EL    = 8'h4B;  // K
  localparam logic [7:0] CH_LBRK  = 8'h5B;  // [
  localparam logic [7:0] CH_RIS   = 8'h63;  // c
  localparam logic [7:0] CH_HVP   = 8'h66;  // f
  localparam logic [7:0] CH_SET   = 8'h68;  // h
  localparam logic [7:0] CH_RESET = 8'h6C;  // l
  localparam logic [7:0] CH_SGR   = 8'h6D;  // m
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  // SGR and DEC mode numbers
  localparam logic [15:0] SGR_RESET  = 16'd0;
  localparam logic [15:0] SGR_BOLD   = 16'd1;
  localparam logic [15:0] SGR_NOBOLD = 16'd22;
  localparam logic [15:0] SGR_FG     = 16'd30;
  localparam logic [15:0] SGR_BG     = 16'd40;
  localparam logic [15:0] DEC_CURSOR = 16'd25;

  localparam logic [31:0] FG_RST = 32'hFFAAAAAA;
  localparam logic [31:0] BG_RST = 32'h00000000;

  // Signed working coordinate
  typedef logic signed [23:0] coord_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_IDLE, OP_LOAD, OP_STEP, OP_NL, OP_BS, OP_WALK,
    OP_FILLA, OP_FILLB, OP_MUL, OP_MOVE, OP_SAT, OP_NEXT
  } op_e;

  // Kind of work a final byte needs
  typedef enum logic [1:0] {FIN_NONE, FIN_WALK, FIN_FILL, FIN_MOVE} fin_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic nl_req;
    logic bs_req;
    fin_e fin;
    logic walk_last;
    logic out_last;
  } stat_t;

  typedef struct packed {
    logic [11:0] width;
    logic [11:0] height;
    logic [7:0]  border;
    logic [3:0]  gap;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [11:0] x;
    logic [11:0] y;
    logic [11:0] w;
    logic [11:0] h;
    logic [6:0]  g;
  } pend_t;

  typedef struct packed {
    pend_t       item;
    logic [31:0] fg;
    logic [31:0] bg;
    logic [11:0] cx;
    logic [11:0] cy;
    logic        vis;
    logic        last;
  } res_t;

  typedef struct packed {
    logic        ok;
    logic [11:0] x;
    logic [11:0] y;
    logic [11:0] w;
    logic [11:0] h;
  } clip_t;

  function automatic logic [31:0] pal_normal(input logic [2:0] idx);
    logic [31:0] c;
    case (idx)
      3'd0:    c = 32'hFF000000;
      3'd1:    c = 32'hFFAA0000;
      3'd2:    c = 32'hFF00AA00;
      3'd3:    c = 32'hFFAA5500;
      3'd4:    c = 32'hFF0000AA;
      3'd5:    c = 32'hFFAA00AA;
      3'd6:    c = 32'hFF00AAAA;
      default: c = 32'hFFAAAAAA;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] pal_bright(input logic [2:0] idx);
    logic [31:0] c;
    case (idx)
      3'd0:    c = 32'hFF555555;
      3'd1:    c = 32'hFFFF5555;
      3'd2:    c = 32'hFF55FF55;
      3'd3:    c = 32'hFFFFFF55;
      3'd4:    c = 32'hFF5555FF;
      3'd5:    c = 32'hFFFF55FF;
      3'd6:    c = 32'hFF55FFFF;
      default: c = 32'hFFFFFFFF;
    endcase
    return c;
  endfunction

  // Clip a fill rectangle to the screen; ok low means it is dropped
  function automatic clip_t clip(input coord_t x, input coord_t y, input coord_t w,
                                 input coord_t h, input coord_t sw, input coord_t sh);
    clip_t  f;
    coord_t cx, cy, cw, ch;
    cx = x; cy = y; cw = w; ch = h;
    if (cx < 0) begin
      cw = cw + cx;
      cx = '0;
    end
    if (cy < 0) begin
      ch = ch + cy;
      cy = '0;
    end
    f.ok = !(cx >= sw || cy >= sh);
    if (cx + cw > sw) cw = sw - cx;
    if (cy + ch > sh) ch = sh - cy;
    if (cw <= 0 || ch <= 0) f.ok = 1'b0;
    f.x = cx[11:0];
    f.y = cy[11:0];
    f.w = cw[11:0];
    f.h = ch[11:0];
    return f;
  endfunction

endpackage

// File: src/ate_ctrl.sv
// Controller state machine of the terminal command engine.
// Depends on ate_pkg; drives the datapath through cmd_t, reads stat_t.
module ate_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  ate_pkg::stat_t stat_i,
  output ate_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_STEP  = 4'd1;
  localparam logic [3:0] S_ROUTE = 4'd2;
  localparam logic [3:0] S_NL    = 4'd3;
  localparam logic [3:0] S_BS    = 4'd4;
  localparam logic [3:0] S_WALK  = 4'd5;
  localparam logic [3:0] S_FA    = 4'd6;
  localparam logic [3:0] S_FB    = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_MOVE  = 4'd9;
  localparam logic [3:0] S_SAT   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0] state_q, state_d;

  // Next state and datapath operation
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = ate_pkg::OP_IDLE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = ate_pkg::OP_LOAD;
          state_d  = S_STEP;
        end
      end
      S_STEP: begin
        cmd_o.op = ate_pkg::OP_STEP;
        state_d  = S_ROUTE;
      end
      S_ROUTE: begin
        if (stat_i.nl_req) state_d = S_NL;
        else if (stat_i.bs_req) state_d = S_BS;
        else begin
          case (stat_i.fin)
            ate_pkg::FIN_WALK: state_d = S_WALK;
            ate_pkg::FIN_FILL: state_d = S_FA;
            ate_pkg::FIN_MOVE: state_d = S_MUL;
            default:           state_d = S_SAT;
          endcase
        end
      end
      S_NL: begin
        cmd_o.op = ate_pkg::OP_NL;
        state_d  = S_SAT;
      end
      S_BS: begin
        cmd_o.op = ate_pkg::OP_BS;
        state_d  = S_SAT;
      end
      S_WALK: begin
        cmd_o.op = ate_pkg::OP_WALK;
        if (stat_i.walk_last) state_d = S_SAT;
      end
      S_FA: begin
        cmd_o.op = ate_pkg::OP_FILLA;
        state_d  = S_FB;
      end
      S_FB: begin
        cmd_o.op = ate_pkg::OP_FILLB;
        state_d  = S_SAT;
      end
      S_MUL: begin
        cmd_o.op = ate_pkg::OP_MUL;
        state_d  = S_MOVE;
      end
      S_MOVE: begin
        cmd_o.op = ate_pkg::OP_MOVE;
        state_d  = S_SAT;
      end
      S_SAT: begin
        cmd_o.op = ate_pkg::OP_SAT;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          if (stat_i.out_last) state_d = S_IDLE;
          else cmd_o.op = ate_pkg::OP_NEXT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule

// File: src/ate_dp.sv
// Datapath of the terminal command engine: parser state, parameters,
// colours, cursor, fill clipping and the two-entry result buffer. Uses ate_pkg.
module ate_dp #(
  parameter int PARAM_SLOTS = ate_pkg::PARAM_SLOTS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ate_pkg::cmd_t  cmd_i,
  input  logic [7:0]     byte_in_i,
  input  ate_pkg::cfg_t  cfg_i,
  output ate_pkg::stat_t stat_o,
  output ate_pkg::res_t  res_o
);

  localparam int TW = $clog2(PARAM_SLOTS + 1);
  localparam int IW = $clog2(PARAM_SLOTS);

  typedef ate_pkg::coord_t coord_t;

  // Parser and display state
  logic [1:0]  mode_q;
  logic [15:0] store_q [PARAM_SLOTS];
  logic [TW-1:0] total_q;
  logic [15:0] accum_q;
  logic        priv_q, wpriv_q, bold_q, vis_q;
  logic [31:0] fg_q, bg_q;
  coord_t      px_q, py_q;
  logic [7:0]  byte_q, fb_q;
  logic        nl_q, bs_q;
  ate_pkg::fin_e fin_q;
  logic [IW-1:0] walk_q;
  coord_t      prod_q, prod2_q;
  ate_pkg::pend_t pend_q [2];
  logic [1:0]  cnt_q;
  logic        oidx_q;

  // Derived geometry
  coord_t sw, sh, lft, rgt, bot, lh;
  assign sw  = coord_t'(cfg_i.width);
  assign sh  = coord_t'(cfg_i.height);
  assign lft = coord_t'(cfg_i.border);
  assign rgt = sw - lft;
  assign bot = sh - lft;
  assign lh  = coord_t'(ate_pkg::GLYPH_ROWS) + coord_t'(cfg_i.gap);

  // Byte classification
  logic is_draw, is_glyph, is_bsp, is_digit;
  logic [6:0] gcode;
  assign is_draw = (mode_q == ate_pkg::MODE_NORMAL && byte_q != ate_pkg::CH_ESC) ||
                   (mode_q == ate_pkg::MODE_ESC && byte_q != ate_pkg::CH_LBRK &&
                    byte_q != ate_pkg::CH_RIS);
  assign is_bsp   = (byte_q == ate_pkg::CH_BS) || (byte_q == ate_pkg::CH_DEL);
  assign is_glyph = is_draw && !is_bsp && byte_q != ate_pkg::CH_CR &&
                    byte_q != ate_pkg::CH_LF;
  assign is_digit = (byte_q >= ate_pkg::CH_ZERO) && (byte_q <= ate_pkg::CH_NINE);
  assign gcode    = (byte_q >= ate_pkg::CH_SPACE && byte_q <= ate_pkg::CH_TILDE) ?
                    byte_q[6:0] : ate_pkg::CH_QUEST[6:0];

  // First two parameters and the count argument
  logic [15:0] p0, p1, pcur, cnt_arg, row_arg, col_arg;
  assign p0      = store_q[0];
  assign p1      = store_q[1];
  assign pcur    = store_q[walk_q];
  assign cnt_arg = (p0 != '0) ? p0 : 16'd1;
  assign row_arg = (p0 != '0) ? p0 - 16'd1 : '0;
  assign col_arg = (total_q > TW'(1) && p1 != '0) ? p1 - 16'd1 : '0;

  // Digit accumulation with saturation
  logic [19:0] dig;
  assign dig = 20'(accum_q) * 20'd10 + 20'(byte_q[3:0]);

  // Fill operands for ED and EL
  coord_t fa_x, fa_y, fa_w, fa_h, fb_x, fb_y, fb_w, fb_h, to_r;
  logic   fa_v, fb_v;
  always_comb begin
    to_r = rgt - px_q;
    if (to_r < 0) to_r = '0;
    fa_v = 1'b0; fa_x = px_q; fa_y = py_q; fa_w = to_r; fa_h = lh;
    fb_v = 1'b0; fb_x = lft;  fb_y = py_q + lh; fb_w = rgt - lft; fb_h = bot - (py_q + lh);
    if (fb_q == ate_pkg::CH_ED) begin
      case (p0)
        16'd0: begin
          fa_v = 1'b1;
          fb_v = 1'b1;
        end
        16'd1: begin
          fa_v = 1'b1; fa_x = lft; fa_y = lft; fa_w = rgt - lft; fa_h = py_q - lft;
          fb_v = 1'b1; fb_x = lft; fb_y = py_q;
          fb_w = px_q - lft + coord_t'(ate_pkg::CELL_W); fb_h = lh;
        end
        16'd2: begin
          fa_v = 1'b1; fa_x = lft; fa_y = lft; fa_w = rgt - lft; fa_h = bot - lft;
        end
        default: ;
      endcase
    end else begin
      case (p0)
        16'd0: fa_v = 1'b1;
        16'd1: begin
          fa_v = 1'b1; fa_x = lft; fa_w = px_q - lft;
        end
        16'd2: begin
          fa_v = 1'b1; fa_x = lft; fa_w = rgt - lft;
        end
        default: ;
      endcase
    end
  end

  // Result produced this cycle, if any
  ate_pkg::clip_t cl;
  ate_pkg::pend_t em;
  logic           em_v, scroll;
  assign scroll = (py_q + lh + lh > bot);
  always_comb begin
    em   = '0;
    em_v = 1'b0;
    cl   = ate_pkg::clip(fa_x, fa_y, fa_w, fa_h, sw, sh);
    case (cmd_i.op)
      ate_pkg::OP_STEP: begin
        if (mode_q == ate_pkg::MODE_ESC && byte_q == ate_pkg::CH_RIS) begin
          em_v   = 1'b1;
          em.cmd = ate_pkg::CMD_CLEAR;
        end else if (is_glyph) begin
          em_v   = 1'b1;
          em.cmd = ate_pkg::CMD_GLYPH;
          em.x   = px_q[11:0];
          em.y   = py_q[11:0];
          em.g   = gcode;
        end
      end
      ate_pkg::OP_NL: begin
        if (scroll) begin
          em_v   = 1'b1;
          em.cmd = ate_pkg::CMD_SCROLL;
          em.h   = (lh > sh) ? sh[11:0] : lh[11:0];
        end
      end
      ate_pkg::OP_BS, ate_pkg::OP_FILLA, ate_pkg::OP_FILLB: begin
        if (cmd_i.op == ate_pkg::OP_BS)
          cl = ate_pkg::clip(px_q, py_q, coord_t'(ate_pkg::CELL_W), lh, sw, sh);
        else if (cmd_i.op == ate_pkg::OP_FILLB)
          cl = ate_pkg::clip(fb_x, fb_y, fb_w, fb_h, sw, sh);
        em_v = cl.ok && (cmd_i.op == ate_pkg::OP_BS ||
                         (cmd_i.op == ate_pkg::OP_FILLA && fa_v) ||
                         (cmd_i.op == ate_pkg::OP_FILLB && fb_v));
        em.cmd = ate_pkg::CMD_FILL;
        em.x = cl.x; em.y = cl.y; em.w = cl.w; em.h = cl.h;
      end
      ate_pkg::OP_SAT: em_v = (cnt_q == 2'd0);
      default: ;
    endcase
  end

  // Cursor moves
  logic [15:0] mul_a;
  coord_t      mul_b, nx, ny;
  logic        is_h;
  assign is_h  = (fb_q == ate_pkg::CH_HOME) || (fb_q == ate_pkg::CH_HVP);
  assign mul_a = is_h ? row_arg : cnt_arg;
  assign mul_b = (fb_q == ate_pkg::CH_FWD || fb_q == ate_pkg::CH_BACK) ?
                 coord_t'(ate_pkg::CELL_W) : lh;

  // Cursor after a glyph or backspace
  coord_t step_x;
  assign step_x = is_bsp ? px_q - coord_t'(ate_pkg::CELL_W) :
                           px_q + coord_t'(ate_pkg::CELL_W);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ate_pkg::MODE_NORMAL;
      store_q <= '{default: '0};
      total_q <= '0;
      accum_q <= '0;
      priv_q  <= 1'b0;
      wpriv_q <= 1'b0;
      bold_q  <= 1'b0;
      vis_q   <= 1'b1;
      fg_q    <= ate_pkg::FG_RST;
      bg_q    <= ate_pkg::BG_RST;
      px_q    <= coord_t'(ate_pkg::BORDER_RST);
      py_q    <= coord_t'(ate_pkg::BORDER_RST);
      byte_q  <= '0;
      fb_q    <= '0;
      nl_q    <= 1'b0;
      bs_q    <= 1'b0;
      fin_q   <= ate_pkg::FIN_NONE;
      walk_q  <= '0;
      prod_q  <= '0;
      prod2_q <= '0;
      pend_q  <= '{default: '0};
      cnt_q   <= '0;
      oidx_q  <= 1'b0;
    end else begin
      // Append a result beat
      if (em_v && cnt_q != 2'd2) begin
        pend_q[cnt_q[0]] <= em;
        cnt_q <= cnt_q + 2'd1;
      end
      case (cmd_i.op)
        ate_pkg::OP_LOAD: begin
          byte_q <= byte_in_i;
          cnt_q  <= '0;
          oidx_q <= 1'b0;
          nl_q   <= 1'b0;
          bs_q   <= 1'b0;
          fin_q  <= ate_pkg::FIN_NONE;
        end
        ate_pkg::OP_STEP: begin
          if (mode_q == ate_pkg::MODE_CSI) begin
            if (is_digit) begin
              accum_q <= (dig > 20'(ate_pkg::PARAM_MAX)) ? ate_pkg::PARAM_MAX : dig[15:0];
            end else if (byte_q == ate_pkg::CH_QUEST) begin
              priv_q <= 1'b1;
            end else begin
              if (total_q < TW'(PARAM_SLOTS)) begin
                store_q[total_q[IW-1:0]] <= accum_q;
                total_q <= total_q + TW'(1);
              end
              if (byte_q == ate_pkg::CH_SEMI) begin
                accum_q <= '0;
              end else begin
                mode_q  <= ate_pkg::MODE_NORMAL;
                priv_q  <= 1'b0;
                wpriv_q <= priv_q;
                fb_q    <= byte_q;
                walk_q  <= '0;
                case (byte_q)
                  ate_pkg::CH_SET, ate_pkg::CH_RESET, ate_pkg::CH_SGR:
                    fin_q <= ate_pkg::FIN_WALK;
                  ate_pkg::CH_ED, ate_pkg::CH_EL:
                    fin_q <= ate_pkg::FIN_FILL;
                  ate_pkg::CH_UP, ate_pkg::CH_DOWN, ate_pkg::CH_FWD, ate_pkg::CH_BACK,
                  ate_pkg::CH_HOME, ate_pkg::CH_HVP:
                    fin_q <= ate_pkg::FIN_MOVE;
                  default: fin_q <= ate_pkg::FIN_NONE;
                endcase
              end
            end
          end else if (mode_q == ate_pkg::MODE_NORMAL && byte_q == ate_pkg::CH_ESC) begin
            mode_q <= ate_pkg::MODE_ESC;
          end else if (mode_q == ate_pkg::MODE_ESC && byte_q == ate_pkg::CH_LBRK) begin
            mode_q  <= ate_pkg::MODE_CSI;
            total_q <= '0;
            accum_q <= '0;
            priv_q  <= 1'b0;
          end else if (mode_q == ate_pkg::MODE_ESC && byte_q == ate_pkg::CH_RIS) begin
            mode_q <= ate_pkg::MODE_NORMAL;
            fg_q   <= ate_pkg::pal_normal(3'd7);
            bg_q   <= ate_pkg::pal_normal(3'd0);
            bold_q <= 1'b0;
            px_q   <= '0;
            py_q   <= '0;
          end else begin
            // Ordinary byte: CR, LF, backspace or glyph
            mode_q <= ate_pkg::MODE_NORMAL;
            if (byte_q == ate_pkg::CH_CR) begin
              px_q <= lft;
            end else if (byte_q == ate_pkg::CH_LF) begin
              px_q <= lft;
              nl_q <= 1'b1;
            end else if (is_bsp) begin
              if (step_x < lft) px_q <= lft;
              else begin
                px_q <= step_x;
                bs_q <= 1'b1;
              end
            end else if (step_x + coord_t'(ate_pkg::CELL_W) > rgt) begin
              px_q <= lft;
              nl_q <= 1'b1;
            end else begin
              px_q <= step_x;
            end
          end
        end
        ate_pkg::OP_NL: begin
          if (!scroll) py_q <= py_q + lh;
        end
        ate_pkg::OP_WALK: begin
          walk_q <= walk_q + IW'(1);
          if (fb_q == ate_pkg::CH_SGR) begin
            if (pcur == ate_pkg::SGR_RESET) begin
              fg_q   <= ate_pkg::pal_normal(3'd7);
              bg_q   <= ate_pkg::pal_normal(3'd0);
              bold_q <= 1'b0;
            end else if (pcur == ate_pkg::SGR_BOLD) begin
              bold_q <= 1'b1;
            end else if (pcur == ate_pkg::SGR_NOBOLD) begin
              bold_q <= 1'b0;
            end else if (pcur inside {[16'd30:16'd37]}) begin
              fg_q <= bold_q ? ate_pkg::pal_bright(3'(pcur - ate_pkg::SGR_FG)) :
                               ate_pkg::pal_normal(3'(pcur - ate_pkg::SGR_FG));
            end else if (pcur inside {[16'd40:16'd47]}) begin
              bg_q <= ate_pkg::pal_normal(3'(pcur - ate_pkg::SGR_BG));
            end
          end else if (wpriv_q && pcur == ate_pkg::DEC_CURSOR) begin
            vis_q <= (fb_q == ate_pkg::CH_SET);
          end
        end
        ate_pkg::OP_FILLA: begin
          if (fb_q == ate_pkg::CH_ED && p0 == 16'd2) begin
            px_q <= lft;
            py_q <= lft;
          end
        end
        ate_pkg::OP_MUL: begin
          prod_q  <= coord_t'(21'(mul_a) * 21'(mul_b[4:0]));
          prod2_q <= coord_t'(col_arg) * coord_t'(ate_pkg::CELL_W);
        end
        ate_pkg::OP_MOVE: begin
          case (fb_q)
            ate_pkg::CH_UP:   py_q <= (py_q - prod_q < lft) ? lft : py_q - prod_q;
            ate_pkg::CH_DOWN: py_q <= (py_q + prod_q >= bot) ? bot - lh : py_q + prod_q;
            ate_pkg::CH_FWD:
              px_q <= (px_q + prod_q >= rgt) ? rgt - coord_t'(ate_pkg::CELL_W) : px_q + prod_q;
            ate_pkg::CH_BACK: px_q <= (px_q - prod_q < lft) ? lft : px_q - prod_q;
            default: begin
              px_q <= nx;
              py_q <= ny;
            end
          endcase
        end
        ate_pkg::OP_SAT: begin
          if (px_q < 0) px_q <= '0;
          else if (px_q > 24'sd4095) px_q <= 24'sd4095;
          if (py_q < 0) py_q <= '0;
          else if (py_q > 24'sd4095) py_q <= 24'sd4095;
        end
        ate_pkg::OP_NEXT: oidx_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Absolute position for H and f
  always_comb begin
    nx = lft + prod2_q;
    ny = lft + prod_q;
    if (nx >= rgt) nx = rgt - coord_t'(ate_pkg::CELL_W);
    if (ny >= bot) ny = bot - lh;
  end

  // Status to the controller
  assign stat_o.nl_req    = nl_q;
  assign stat_o.bs_req    = bs_q;
  assign stat_o.fin       = fin_q;
  assign stat_o.walk_last = (TW'(walk_q) + TW'(1) >= total_q);
  assign stat_o.out_last  = (2'(oidx_q) + 2'd1 >= cnt_q);

  // Result beat
  assign res_o.item = pend_q[oidx_q];
  assign res_o.fg   = fg_q;
  assign res_o.bg   = bg_q;
  assign res_o.cx   = px_q[11:0];
  assign res_o.cy   = py_q[11:0];
  assign res_o.vis  = vis_q;
  assign res_o.last = stat_o.out_last;

endmodule

// File: src/ansi_terminal_command_engine.sv
// ANSI terminal command engine: one console byte in, one or two render commands out.
// First beat follows the step, route and saturate states; a line feed, wrap or backspace
// fill adds the newline or backspace state, SGR/DEC mode finals walk each stored parameter,
// ED/EL add fill states A and B, moves the multiply and move states. One byte in flight:
// the next can be taken in the cycle after the last beat. Reset (rst_ni low, async)
// restores register defaults, normal parser mode, border-corner cursor, grey on black.
module ansi_terminal_command_engine #(
  parameter int PARAM_SLOTS = ate_pkg::PARAM_SLOTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  command_o,
  output logic [11:0] rect_x_o,
  output logic [11:0] rect_y_o,
  output logic [11:0] rect_w_o,
  output logic [11:0] rect_h_o,
  output logic [6:0]  glyph_o,
  output logic [31:0] fg_color_o,
  output logic [31:0] bg_color_o,
  output logic [11:0] cursor_x_o,
  output logic [11:0] cursor_y_o,
  output logic        cursor_on_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ate_pkg::cfg_t  cfg_q;
  ate_pkg::cmd_t  cmd;
  ate_pkg::stat_t stat;
  ate_pkg::res_t  res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= ate_pkg::WIDTH_RST;
      cfg_q.height <= ate_pkg::HEIGHT_RST;
      cfg_q.border <= ate_pkg::BORDER_RST;
      cfg_q.gap    <= ate_pkg::GAP_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        ate_pkg::REG_WIDTH:  cfg_q.width  <= pwdata[11:0];
        ate_pkg::REG_HEIGHT: cfg_q.height <= pwdata[11:0];
        ate_pkg::REG_BORDER: cfg_q.border <= pwdata[7:0];
        ate_pkg::REG_GAP:    cfg_q.gap    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[3:2])
      ate_pkg::REG_WIDTH:  prdata = 32'(cfg_q.width);
      ate_pkg::REG_HEIGHT: prdata = 32'(cfg_q.height);
      ate_pkg::REG_BORDER: prdata = 32'(cfg_q.border);
      ate_pkg::REG_GAP:    prdata = 32'(cfg_q.gap);
      default:             prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  ate_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ate_dp #(
    .PARAM_SLOTS (PARAM_SLOTS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .byte_in_i (byte_in_i),
    .cfg_i     (cfg_q),
    .stat_o    (stat),
    .res_o     (res)
  );

  assign command_o   = res.item.cmd;
  assign rect_x_o    = res.item.x;
  assign rect_y_o    = res.item.y;
  assign rect_w_o    = res.item.w;
  assign rect_h_o    = res.item.h;
  assign glyph_o     = res.item.g;
  assign fg_color_o  = res.fg;
  assign bg_color_o  = res.bg;
  assign cursor_x_o  = res.cx;
  assign cursor_y_o  = res.cy;
  assign cursor_on_o = res.vis;
  assign last_o      = res.last;

endmodule

// File: src/ate_chk.sv
// Port-level checker for the terminal command engine, bound to the top level.
// Depends on ate_pkg for the command codes.
module ate_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  command_o,
  input logic [6:0]  glyph_o,
  input logic        last_o
);

  // A held result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // No byte is taken while results are being offered
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while results pending");

  // A beat that is not the last one is followed by another
  a_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("missing second result beat");

  // Glyph codes appear only on draw commands and are printable
  a_glyph: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (command_o == ate_pkg::CMD_GLYPH) ?
      (glyph_o >= 7'd32 && glyph_o <= 7'd126) : (glyph_o == 7'd0))
    else $error("bad glyph code");

endmodule

bind ansi_terminal_command_engine ate_chk u_ate_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .command_o   (command_o),
  .glyph_o     (glyph_o),
  .last_o      (last_o)
);

// File: tb/sv/ansi_terminal_command_engine_tb.sv
// Self-checking bench for the ANSI terminal command engine: console bytes in, render beats out.
// Uses ate_pkg for codes and the result layout; predicts every beat in-bench and compares.
module ansi_terminal_command_engine_tb;
  import ate_pkg::*;

  localparam int WDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  byte_in_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  command_o;
  logic [11:0] rect_x_o, rect_y_o, rect_w_o, rect_h_o;
  logic [6:0]  glyph_o;
  logic [31:0] fg_color_o, bg_color_o;
  logic [11:0] cursor_x_o, cursor_y_o;
  logic        cursor_on_o, last_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ansi_terminal_command_engine u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bytes waiting to be sent and beats waiting to be seen
  logic [7:0] tx_bytes[$];
  res_t       beats_due[$];
  int         errors = 0;
  int         idle_pct = 0;
  int         stall_pct = 0;
  int         hold_cnt = 0;
  bit         hold_go = 1'b0;
  int         wdog = 0;

  // Shadow copy of configuration and engine state
  int          sh_w, sh_h, sh_b, sh_g;
  logic [1:0]  pm;
  logic [15:0] pstore[PARAM_SLOTS];
  int          ptotal, paccum;
  bit          priv_f, bold_f, vis_f;
  logic [31:0] fore_c, back_c;
  int          cur_x, cur_y;
  pend_t       cmds[2];
  int          ncmd;

  function automatic void add_cmd(logic [2:0] c, int x, int y, int w, int h, logic [6:0] g);
    if (ncmd < 2) begin
      cmds[ncmd].cmd = c;
      cmds[ncmd].x = x[11:0];
      cmds[ncmd].y = y[11:0];
      cmds[ncmd].w = w[11:0];
      cmds[ncmd].h = h[11:0];
      cmds[ncmd].g = g;
      ncmd++;
    end
  endfunction

  // Clipped rectangle fill; empty or off-screen rectangles are dropped
  function automatic void fill_rect(int x, int y, int w, int h);
    if (x < 0) begin
      w += x;
      x = 0;
    end
    if (y < 0) begin
      h += y;
      y = 0;
    end
    if (x >= sh_w || y >= sh_h) return;
    if (x + w > sh_w) w = sh_w - x;
    if (y + h > sh_h) h = sh_h - y;
    if (w <= 0 || h <= 0) return;
    add_cmd(CMD_FILL, x, y, w, h, '0);
  endfunction

  function automatic void line_feed();
    int lh;
    lh = GLYPH_ROWS + sh_g;
    cur_y += lh;
    if (cur_y + lh > sh_h - sh_b) begin
      add_cmd(CMD_SCROLL, 0, 0, 0, (lh > sh_h) ? sh_h : lh, '0);
      cur_y -= lh;
    end
  endfunction

  function automatic void put_byte(logic [7:0] b);
    logic [6:0] g;
    if (b == CH_CR) begin
      cur_x = sh_b;
    end else if (b == CH_LF) begin
      cur_x = sh_b;
      line_feed();
    end else if (b == CH_BS || b == CH_DEL) begin
      cur_x -= CELL_W;
      if (cur_x < sh_b) cur_x = sh_b;
      else fill_rect(cur_x, cur_y, CELL_W, GLYPH_ROWS + sh_g);
    end else begin
      g = (b >= CH_SPACE && b <= CH_TILDE) ? b[6:0] : CH_QUEST[6:0];
      add_cmd(CMD_GLYPH, cur_x & 12'hFFF, cur_y & 12'hFFF, 0, 0, g);
      cur_x += CELL_W;
      if (cur_x + CELL_W > sh_w - sh_b) begin
        cur_x = sh_b;
        line_feed();
      end
    end
  endfunction

  function automatic int rep_count();
    return (ptotal > 0 && pstore[0] > 0) ? int'(pstore[0]) : 1;
  endfunction

  // Final byte of a control sequence
  function automatic void do_final(logic [7:0] f);
    int lh, l, t, r, bt, pmode, n, row, col, nx, ny;
    lh = GLYPH_ROWS + sh_g;
    l = sh_b;
    t = sh_b;
    r = sh_w - sh_b;
    bt = sh_h - sh_b;
    pmode = (ptotal > 0) ? int'(pstore[0]) : 0;
    if (f == CH_SET || f == CH_RESET) begin
      if (priv_f)
        for (int i = 0; i < ptotal; i++)
          if (pstore[i] == DEC_CURSOR) vis_f = (f == CH_SET);
    end else if (f == CH_SGR) begin
      if (ptotal == 0) begin
        fore_c = pal_normal(3'd7);
        back_c = pal_normal(3'd0);
        bold_f = 1'b0;
      end
      for (int i = 0; i < ptotal; i++) begin
        n = pstore[i];
        if (n == SGR_RESET) begin
          fore_c = pal_normal(3'd7);
          back_c = pal_normal(3'd0);
          bold_f = 1'b0;
        end else if (n == SGR_BOLD) begin
          bold_f = 1'b1;
        end else if (n == SGR_NOBOLD) begin
          bold_f = 1'b0;
        end else if (n >= SGR_FG && n <= SGR_FG + 7) begin
          fore_c = bold_f ? pal_bright(3'(n - SGR_FG)) : pal_normal(3'(n - SGR_FG));
        end else if (n >= SGR_BG && n <= SGR_BG + 7) begin
          back_c = pal_normal(3'(n - SGR_BG));
        end
      end
    end else if (f == CH_ED) begin
      if (pmode == 2) begin
        fill_rect(l, t, r - l, bt - t);
        cur_x = l;
        cur_y = t;
      end else if (pmode == 0) begin
        fill_rect(cur_x, cur_y, (r - cur_x < 0) ? 0 : r - cur_x, lh);
        fill_rect(l, cur_y + lh, r - l, bt - (cur_y + lh));
      end else if (pmode == 1) begin
        fill_rect(l, t, r - l, cur_y - t);
        fill_rect(l, cur_y, cur_x - l + CELL_W, lh);
      end
    end else if (f == CH_EL) begin
      if (pmode == 0) fill_rect(cur_x, cur_y, (r - cur_x < 0) ? 0 : r - cur_x, lh);
      else if (pmode == 1) fill_rect(l, cur_y, cur_x - l, lh);
      else if (pmode == 2) fill_rect(l, cur_y, r - l, lh);
    end else if (f == CH_UP) begin
      ny = cur_y - rep_count() * lh;
      cur_y = (ny < t) ? t : ny;
    end else if (f == CH_DOWN) begin
      ny = cur_y + rep_count() * lh;
      cur_y = (ny >= bt) ? bt - lh : ny;
    end else if (f == CH_FWD) begin
      nx = cur_x + rep_count() * CELL_W;
      cur_x = (nx >= r) ? r - CELL_W : nx;
    end else if (f == CH_BACK) begin
      nx = cur_x - rep_count() * CELL_W;
      cur_x = (nx < l) ? l : nx;
    end else if (f == CH_HOME || f == CH_HVP) begin
      row = (ptotal > 0 && pstore[0] > 0) ? int'(pstore[0]) - 1 : 0;
      col = (ptotal > 1 && pstore[1] > 0) ? int'(pstore[1]) - 1 : 0;
      nx = l + col * CELL_W;
      ny = t + row * lh;
      if (nx >= r) nx = r - CELL_W;
      if (ny >= bt) ny = bt - lh;
      cur_x = nx;
      cur_y = ny;
    end
  endfunction

  function automatic void store_param();
    if (ptotal < PARAM_SLOTS) begin
      pstore[ptotal] = paccum[15:0];
      ptotal++;
    end
  endfunction

  // Advance the shadow engine by one byte and queue the beats it causes
  function automatic void predict_beats(logic [7:0] b);
    res_t r;
    int   v;
    ncmd = 0;
    if (pm == MODE_ESC) begin
      if (b == CH_LBRK) begin
        pm = MODE_CSI;
        ptotal = 0;
        paccum = 0;
        priv_f = 1'b0;
        foreach (pstore[i]) pstore[i] = '0;
      end else if (b == CH_RIS) begin
        fore_c = pal_normal(3'd7);
        back_c = pal_normal(3'd0);
        bold_f = 1'b0;
        add_cmd(CMD_CLEAR, 0, 0, 0, 0, '0);
        cur_x = 0;
        cur_y = 0;
        pm = MODE_NORMAL;
      end else begin
        pm = MODE_NORMAL;
        put_byte(b);
      end
    end else if (pm == MODE_CSI) begin
      if (b >= CH_ZERO && b <= CH_NINE) begin
        v = paccum * 10 + int'(b - CH_ZERO);
        paccum = (v > PARAM_MAX) ? int'(PARAM_MAX) : v;
      end else if (b == CH_QUEST) begin
        priv_f = 1'b1;
      end else if (b == CH_SEMI) begin
        store_param();
        paccum = 0;
      end else begin
        store_param();
        do_final(b);
        pm = MODE_NORMAL;
        priv_f = 1'b0;
      end
    end else begin
      if (b == CH_ESC) pm = MODE_ESC;
      else put_byte(b);
    end
    cur_x = (cur_x < 0) ? 0 : (cur_x > 4095) ? 4095 : cur_x;
    cur_y = (cur_y < 0) ? 0 : (cur_y > 4095) ? 4095 : cur_y;
    if (ncmd == 0) add_cmd(CMD_NONE, 0, 0, 0, 0, '0);
    for (int k = 0; k < ncmd; k++) begin
      r.item = cmds[k];
      r.fg = fore_c;
      r.bg = back_c;
      r.cx = cur_x[11:0];
      r.cy = cur_y[11:0];
      r.vis = vis_f;
      r.last = (k == ncmd - 1);
      beats_due.push_back(r);
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // Input driver: hold the byte until taken, then offer the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      byte_in_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_beats(byte_in_i);
        void'(tx_bytes.pop_front());
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tx_bytes.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_valid_i <= 1'b1;
          byte_in_i <= tx_bytes[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compare each taken beat with the oldest prediction
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (beats_due.size() == 0) begin
        report_mismatch("unexpected beat, command", command_o, '0);
      end else begin
        e = beats_due.pop_front();
        if (command_o !== e.item.cmd) report_mismatch("command", command_o, e.item.cmd);
        if (rect_x_o !== e.item.x) report_mismatch("rect_x", rect_x_o, e.item.x);
        if (rect_y_o !== e.item.y) report_mismatch("rect_y", rect_y_o, e.item.y);
        if (rect_w_o !== e.item.w) report_mismatch("rect_w", rect_w_o, e.item.w);
        if (rect_h_o !== e.item.h) report_mismatch("rect_h", rect_h_o, e.item.h);
        if (glyph_o !== e.item.g) report_mismatch("glyph", glyph_o, e.item.g);
        if (fg_color_o !== e.fg) report_mismatch("fg_color", fg_color_o, e.fg);
        if (bg_color_o !== e.bg) report_mismatch("bg_color", bg_color_o, e.bg);
        if (cursor_x_o !== e.cx) report_mismatch("cursor_x", cursor_x_o, e.cx);
        if (cursor_y_o !== e.cy) report_mismatch("cursor_y", cursor_y_o, e.cy);
        if (cursor_on_o !== e.vis) report_mismatch("cursor_on", cursor_on_o, e.vis);
        if (last_o !== e.last) report_mismatch("last", last_o, e.last);
      end
    end
    out_stall_i <= (hold_cnt != 0) || ($urandom_range(99) < stall_pct);
  end

  // Long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (hold_go && hold_cnt == 0) hold_cnt <= HOLD_CYCLES;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  // Watchdog on cycles with no beat taken on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, int val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WIDTH:  sh_w = val & 12'hFFF;
      REG_HEIGHT: sh_h = val & 12'hFFF;
      REG_BORDER: sh_b = val & 8'hFF;
      default:    sh_g = val & 4'hF;
    endcase
  endtask

  task automatic set_screen(int w, int h, int b, int g);
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
    reg_write(REG_BORDER, b);
    reg_write(REG_GAP, g);
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
  endtask

  task automatic push_csi(string body);
    tx_bytes.push_back(CH_ESC);
    tx_bytes.push_back(CH_LBRK);
    push_str(body);
  endtask

  // One random control sequence, mostly well formed
  task automatic push_rand_csi();
    logic [7:0] finals[11];
    int n, v;
    finals = '{CH_UP, CH_DOWN, CH_FWD, CH_BACK, CH_HOME, CH_HVP, CH_ED, CH_EL, CH_SGR,
               CH_SET, CH_RESET};
    tx_bytes.push_back(CH_ESC);
    tx_bytes.push_back(CH_LBRK);
    if ($urandom_range(5) == 0) tx_bytes.push_back(CH_QUEST);
    n = ($urandom_range(15) == 0) ? $urandom_range(17, 20) : $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(5))
        0: v = $urandom_range(0, 2);
        1: v = DEC_CURSOR;
        2: v = $urandom_range(30, 47);
        3: v = $urandom_range(0, 200);
        4: v = $urandom_range(0, 99999);
        default: v = $urandom_range(0, 9);
      endcase
      if (!(i == n - 1 && $urandom_range(3) == 0)) push_str($sformatf("%0d", v));
      if (i < n - 1) tx_bytes.push_back(CH_SEMI);
    end
    if ($urandom_range(9) == 0) tx_bytes.push_back(8'($urandom_range(255)));
    else tx_bytes.push_back(finals[$urandom_range(10)]);
  endtask

  task automatic fill_random(int count);
    int base;
    base = tx_bytes.size();
    while (tx_bytes.size() - base < count) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5: push_rand_csi();
        6: tx_bytes.push_back(CH_LF);
        7: tx_bytes.push_back(CH_CR);
        8: tx_bytes.push_back(($urandom_range(1)) ? CH_BS : CH_DEL);
        9: tx_bytes.push_back(8'($urandom_range(255)));
        10: begin
          tx_bytes.push_back(CH_ESC);
          tx_bytes.push_back(($urandom_range(3) == 0) ? CH_RIS : 8'($urandom_range(255)));
        end
        default: tx_bytes.push_back(8'($urandom_range(CH_SPACE, CH_TILDE)));
      endcase
    end
  endtask

  task automatic drain();
    wait (tx_bytes.size() == 0 && !in_valid_i && beats_due.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    sh_w = WIDTH_RST;
    sh_h = HEIGHT_RST;
    sh_b = BORDER_RST;
    sh_g = GAP_RST;
    pm = MODE_NORMAL;
    foreach (pstore[i]) pstore[i] = '0;
    ptotal = 0;
    paccum = 0;
    priv_f = 1'b0;
    bold_f = 1'b0;
    vis_f = 1'b1;
    fore_c = FG_RST;
    back_c = BG_RST;
    cur_x = BORDER_RST;
    cur_y = BORDER_RST;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, the m, l, h, H, K and J finals, an unknown final, special cases, at reset settings
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    push_str("A~");
    tx_bytes.push_back(CH_BS);
    tx_bytes.push_back(CH_DEL);
    tx_bytes.push_back(CH_LF);
    tx_bytes.push_back(CH_CR);
    tx_bytes.push_back(CH_ESC);
    push_str("x");
    push_csi("1;31;44m");
    push_csi("?25l");
    push_csi("?25h");
    push_csi("99999;3H");
    push_csi("0K");
    push_csi("1J");
    push_csi("2J");
    push_csi("z");
    tx_bytes.push_back(CH_ESC);
    tx_bytes.push_back(CH_RIS);
    drain();

    // Phase 0: defaults, no idling, then a long receiver hold-off
    fill_random(200);
    hold_go = 1'b1;
    repeat (5) @(posedge clk_i);
    hold_go = 1'b0;
    drain();

    // Phase 1: smallest screen, no border or gap; sender mostly idle
    set_screen(16, 16, 0, 0);
    idle_pct = 77;
    fill_random(300);
    drain();

    // Phase 2: largest screen and margins; receiver mostly stalling
    set_screen(4095, 4095, 255, 15);
    idle_pct = 0;
    stall_pct = 77;
    fill_random(300);
    drain();

    // Phase 3: border wider than the screen, both sides idling a little
    set_screen(40, 24, 255, 7);
    idle_pct = 14;
    stall_pct = 14;
    fill_random(200);
    drain();

    // Phase 4: random small-ish geometry, no idling
    set_screen($urandom_range(16, 200), $urandom_range(16, 120), $urandom_range(0, 12),
               $urandom_range(0, 15));
    idle_pct = 0;
    stall_pct = 0;
    fill_random(300);
    drain();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
src/ate_pkg.sv
src/ate_ctrl.sv
src/ate_dp.sv
src/ansi_terminal_command_engine.sv
src/ate_chk.sv
tb/sv/ansi_terminal_command_engine_tb.sv
